### rtl/core/tfwm_pkg.sv
package tfwm_pkg;

    // Filter store capacity and derived widths
    localparam int FILT_DEPTH = 64;
    localparam int FILT_AW    = $clog2(FILT_DEPTH);
    localparam int CNT_W      = FILT_AW + 1;

    // Request commands
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_TOPIC  = 2'd2;
    localparam logic [1:0] CMD_END    = 2'd3;

    // Verdict codes
    localparam logic [1:0] V_UNDECIDED = 2'd0;
    localparam logic [1:0] V_MATCH     = 2'd1;
    localparam logic [1:0] V_NOMATCH   = 2'd2;

    // Special characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } t_in_req;

    typedef struct packed {
        logic matched;
        logic filter_overflow;
    } t_out_res;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic topic_start;
        logic eval;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic start_go;
        logic eval_more;
        logic out_free;
    } t_dp_stat;

endpackage

### rtl/core/tfwm_ctrl.sv
module tfwm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_cmd,
    input  tfwm_pkg::t_dp_stat  i_stat,
    output logic                o_in_ready,
    output tfwm_pkg::t_dp_cmd   o_dp_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       in_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_cmd)
                        tfwm_pkg::CMD_CLEAR: begin
                            o_dp_cmd.clear = 1'b1;
                        end
                        tfwm_pkg::CMD_APPEND: begin
                            o_dp_cmd.append = 1'b1;
                        end
                        tfwm_pkg::CMD_TOPIC: begin
                            o_dp_cmd.topic_start = 1'b1;
                            if (i_stat.start_go) begin
                                n_state = S_EVAL;
                            end
                        end
                        default: begin
                            // hold the result until the output slot frees up
                            if (i_stat.out_free) begin
                                o_dp_cmd.finish = 1'b1;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                    endcase
                end
            end
            S_EVAL: begin
                o_dp_cmd.eval = 1'b1;
                if (!i_stat.eval_more) begin
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_dp_cmd.finish = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/tfwm_dpath.sv
module tfwm_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_data_byte,
    input  tfwm_pkg::t_dp_cmd   i_dp_cmd,
    output tfwm_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tfwm_pkg::t_out_res  o_out_data
);

    localparam int AW = tfwm_pkg::FILT_AW;
    localparam int CW = tfwm_pkg::CNT_W;

    logic [7:0]    r_mem [tfwm_pkg::FILT_DEPTH];
    logic [7:0]    r_rdata;
    logic [7:0]    r_byte;
    logic [7:0]    r_last0;   // second to last stored filter byte
    logic [7:0]    r_last1;   // last stored filter byte
    logic [CW-1:0] r_len;
    logic [CW-1:0] n_len;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] n_pos;
    logic          r_skip;
    logic          n_skip;
    logic [1:0]    r_verdict;
    logic [1:0]    n_verdict;
    logic          r_ovf;
    logic          n_ovf;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [CW-1:0] pos_inc;
    logic          has_room;
    logic          do_write;
    logic          fin_match;
    logic          start_go;

    assign pos_inc  = r_pos + CW'(1);
    assign has_room = (r_len < CW'(tfwm_pkg::FILT_DEPTH));
    assign do_write = i_dp_cmd.append && has_room;

    assign start_go = (r_verdict == tfwm_pkg::V_UNDECIDED)
                   && (!r_skip || (i_data_byte == tfwm_pkg::CH_SLASH))
                   && (r_pos < r_len);

    assign o_stat.start_go  = start_go;
    assign o_stat.eval_more = (r_rdata == tfwm_pkg::CH_PLUS)
                           && (r_byte == tfwm_pkg::CH_SLASH)
                           && (pos_inc < r_len);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        fin_match = 1'b0;
        if (r_verdict == tfwm_pkg::V_MATCH) begin
            fin_match = 1'b1;
        end else if (r_verdict == tfwm_pkg::V_UNDECIDED) begin
            if (r_pos == r_len) begin
                fin_match = 1'b1;
            end else if (r_len >= CW'(2)) begin
                fin_match = (pos_inc < r_len)
                         && (r_last0 == tfwm_pkg::CH_SLASH)
                         && (r_last1 == tfwm_pkg::CH_HASH);
            end
        end
    end

    always_comb begin
        n_len       = r_len;
        n_pos       = r_pos;
        n_skip      = r_skip;
        n_verdict   = r_verdict;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_dp_cmd.clear) begin
            n_len     = '0;
            n_ovf     = 1'b0;
            n_pos     = '0;
            n_skip    = 1'b0;
            n_verdict = tfwm_pkg::V_UNDECIDED;
        end
        if (i_dp_cmd.append) begin
            if (has_room) begin
                n_len = r_len + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (i_dp_cmd.topic_start) begin
            if (r_verdict == tfwm_pkg::V_UNDECIDED
                && (!r_skip || (i_data_byte == tfwm_pkg::CH_SLASH))) begin
                n_skip = 1'b0;
                if (r_pos >= r_len) begin
                    n_verdict = tfwm_pkg::V_NOMATCH;
                end
            end
        end
        if (i_dp_cmd.eval) begin
            if (r_rdata == tfwm_pkg::CH_PLUS) begin
                n_pos = pos_inc;
                if (r_byte != tfwm_pkg::CH_SLASH) begin
                    n_skip = 1'b1;
                end else if (pos_inc >= r_len) begin
                    n_verdict = tfwm_pkg::V_NOMATCH;
                end
            end else if (r_rdata == tfwm_pkg::CH_HASH) begin
                n_verdict = tfwm_pkg::V_MATCH;
            end else if (r_rdata != r_byte) begin
                n_verdict = tfwm_pkg::V_NOMATCH;
            end else begin
                n_pos = pos_inc;
            end
        end
        if (i_dp_cmd.finish) begin
            n_out_valid = 1'b1;
            n_pos       = '0;
            n_skip      = 1'b0;
            n_verdict   = tfwm_pkg::V_UNDECIDED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_pos       <= '0;
            r_skip      <= 1'b0;
            r_verdict   <= tfwm_pkg::V_UNDECIDED;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_skip      <= n_skip;
            r_verdict   <= n_verdict;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Filter store: one write port, one registered read port tracking the next position
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_len[AW-1:0]] <= i_data_byte;
        end
        r_rdata <= r_mem[n_pos[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.topic_start) begin
            r_byte <= i_data_byte;
        end
        if (do_write) begin
            r_last0 <= r_last1;
            r_last1 <= i_data_byte;
        end
        if (i_dp_cmd.finish) begin
            o_out_data.matched         <= fin_match;
            o_out_data.filter_overflow <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/topic_filter_wildcard_match_unit.sv
// Channel | Signals                              | Payload
// --------+--------------------------------------+------------------------------
// request | i_in_valid / o_in_ready / i_in_data  | cmd, data_byte
// result  | o_out_valid / i_out_ready / o_out_data | matched, filter_overflow
//
// Clear, append and unstalled end-of-topic requests, and a topic byte that is ignored
// (verdict decided, level being skipped, filter used up), complete in the idle state. Any
// other topic byte enters an evaluate state, repeated per '+' that a '/' steps over before
// its compare, as every filter byte comes from the store's one registered read port.
// i_rst_n is synchronous and active low; the filter store itself is not cleared.
// A result sits in an output register; an end-of-topic request stalls until it is taken.
module topic_filter_wildcard_match_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tfwm_pkg::t_in_req   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tfwm_pkg::t_out_res  o_out_data
);

    tfwm_pkg::t_dp_cmd  dp_cmd;
    tfwm_pkg::t_dp_stat dp_stat;

    tfwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_in_data.cmd),
        .i_stat     (dp_stat),
        .o_in_ready (o_in_ready),
        .o_dp_cmd   (dp_cmd)
    );

    tfwm_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_in_data.data_byte),
        .i_dp_cmd    (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### tb/tb_topic_filter_wildcard_match_unit.sv
module tb_topic_filter_wildcard_match_unit;

    import tfwm_pkg::*;

    localparam int ITEM_TARGET = 1800;
    localparam int QUIET_TAIL  = 300;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN       = 40;
    localparam int CYCLE_LIMIT = 800000;

    // Predicts the verdict of each end-of-topic request and checks it against the block.
    class match_scoreboard;
        logic [7:0] filt_bytes [FILT_DEPTH];
        int         filt_len;
        int         filt_pos;
        bit         skipping;
        logic [1:0] verdict;
        bit         overflow;
        t_out_res   pending[$];
        int         fail_count;
        int         result_count;
        int         match_count;
        int         overflow_count;

        function new();
            filt_len       = 0;
            overflow       = 1'b0;
            fail_count     = 0;
            result_count   = 0;
            match_count    = 0;
            overflow_count = 0;
            restart_topic();
        endfunction

        function void restart_topic();
            filt_pos = 0;
            skipping = 1'b0;
            verdict  = V_UNDECIDED;
        endfunction

        function void note_request(t_in_req req);
            t_out_res   res;
            bit         done;
            logic [7:0] c;
            case (req.cmd)
                CMD_CLEAR: begin
                    filt_len = 0;
                    overflow = 1'b0;
                    restart_topic();
                end
                CMD_APPEND: begin
                    if (filt_len < FILT_DEPTH) begin
                        filt_bytes[filt_len] = req.data_byte;
                        filt_len++;
                    end else begin
                        overflow = 1'b1;
                    end
                end
                CMD_TOPIC: begin
                    done = (verdict != V_UNDECIDED);
                    if (!done && skipping) begin
                        if (req.data_byte != CH_SLASH) done = 1'b1;
                        else skipping = 1'b0;
                    end
                    // Step over any run of '+' until a byte is compared or a level is skipped
                    while (!done && filt_pos < filt_len) begin
                        c = filt_bytes[filt_pos];
                        if (c == CH_PLUS) begin
                            filt_pos++;
                            if (req.data_byte != CH_SLASH) begin
                                skipping = 1'b1;
                                done     = 1'b1;
                            end
                        end else if (c == CH_HASH) begin
                            verdict = V_MATCH;
                            done    = 1'b1;
                        end else begin
                            if (c != req.data_byte) verdict = V_NOMATCH;
                            else filt_pos++;
                            done = 1'b1;
                        end
                    end
                    if (!done) verdict = V_NOMATCH;
                end
                CMD_END: begin
                    if (verdict == V_MATCH) begin
                        res.matched = 1'b1;
                    end else if (verdict == V_NOMATCH) begin
                        res.matched = 1'b0;
                    end else if (filt_pos == filt_len) begin
                        res.matched = 1'b1;
                    end else if (filt_len < 2) begin
                        res.matched = 1'b0;
                    end else begin
                        res.matched = (filt_pos < filt_len - 1) &&
                                      (filt_bytes[filt_len - 2] == CH_SLASH) &&
                                      (filt_bytes[filt_len - 1] == CH_HASH);
                    end
                    res.filter_overflow = overflow;
                    pending.push_back(res);
                    restart_topic();
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out_res got);
            t_out_res want;
            if (pending.size() == 0) begin
                $error("result with no end-of-topic request waiting: matched %0b filter_overflow %0b",
                       got.matched, got.filter_overflow);
                fail_count++;
                return;
            end
            want = pending.pop_front();
            result_count++;
            if (want.matched) match_count++;
            if (want.filter_overflow) overflow_count++;
            if (got.matched !== want.matched) begin
                $error("matched: expected %0b, actual %0b", want.matched, got.matched);
                fail_count++;
            end
            if (got.filter_overflow !== want.filter_overflow) begin
                $error("filter_overflow: expected %0b, actual %0b",
                       want.filter_overflow, got.filter_overflow);
                fail_count++;
            end
        endfunction
    endclass

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_in_req  in_req    = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_out_res out_res;

    match_scoreboard sb = new();

    bit quiet         = 1'b0;
    bit hold_now      = 1'b0;
    int send_idle_pct = 10;
    int sent_count    = 0;
    int cycle_count   = 0;

    topic_filter_wildcard_match_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_res)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) sb.note_request(in_req);
            if (out_valid && out_ready) sb.check_result(out_res);
        end
    end

    // Offer one request, with an optional idle burst first; return once it is accepted.
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] data);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_req.cmd       = cmd;
        in_req.data_byte = data;
        in_valid         = 1'b1;
        do @(posedge clk); while (!in_ready);
        sent_count++;
    endtask

    // Result side: random stall bursts, one long hold-off, none in the quiet tail.
    initial begin : result_sink
        int  hold_left;
        int  idle_pct;
        int  phase_cycles;
        bit  hold_done;
        hold_left    = 0;
        idle_pct     = 10;
        phase_cycles = 0;
        hold_done    = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            phase_cycles++;
            if (phase_cycles == 150) begin
                phase_cycles = 0;
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 35;
                endcase
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready = 1'b0;
            end else if (hold_now && !hold_done) begin
                // hold off long enough for the output register to fill and stall requests
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                out_ready = 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                hold_left = $urandom_range(1, 12) - 1;
                out_ready = 1'b0;
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] filt_img[$];
        logic [7:0] topic[$];
        logic [7:0] b;
        int         flen;
        int         pick;
        int         ntopics;
        int         idx;
        bit         stop;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty filter: empty topic matches, a non-empty one does not
        send_request(CMD_END, 8'h00);
        send_request(CMD_TOPIC, 8'h00);
        send_request(CMD_END, 8'hFF);
        // one-byte filter: early mismatch ignores the rest, then a left-over topic byte
        send_request(CMD_APPEND, 8'hFF);
        send_request(CMD_TOPIC, 8'h00);
        send_request(CMD_TOPIC, 8'hFF);
        send_request(CMD_END, 8'h00);
        send_request(CMD_TOPIC, 8'hFF);
        send_request(CMD_TOPIC, 8'h00);
        send_request(CMD_END, 8'hFF);
        send_request(CMD_CLEAR, 8'hFF);
        // "+/+/#": plus over an empty level, plus over a word, hash, slash-hash tail
        send_request(CMD_APPEND, CH_PLUS);
        send_request(CMD_APPEND, CH_SLASH);
        send_request(CMD_APPEND, CH_PLUS);
        send_request(CMD_APPEND, CH_SLASH);
        send_request(CMD_APPEND, CH_HASH);
        send_request(CMD_TOPIC, CH_SLASH);
        send_request(CMD_TOPIC, "a");
        send_request(CMD_TOPIC, CH_SLASH);
        send_request(CMD_TOPIC, "x");
        send_request(CMD_END, 8'h00);
        send_request(CMD_TOPIC, CH_SLASH);
        send_request(CMD_END, 8'h00);

        hold_now = 1'b1;

        while (sent_count < ITEM_TARGET) begin
            quiet = (sent_count >= ITEM_TARGET - QUIET_TAIL);
            case ($urandom_range(0, 2))
                0:       send_idle_pct = 0;
                1:       send_idle_pct = 8;
                default: send_idle_pct = 30;
            endcase

            pick = $urandom_range(0, 29);
            if (pick == 0) flen = $urandom_range(60, 70);
            else if (pick < 3) flen = $urandom_range(9, 40);
            else flen = $urandom_range(0, 8);
            filt_img.delete();
            for (int i = 0; i < flen; i++) begin
                case ($urandom_range(0, 9))
                    0, 1:    b = CH_PLUS;
                    2:       b = CH_HASH;
                    3, 4:    b = CH_SLASH;
                    5:       b = 8'($urandom);
                    default: b = 8'("a" + $urandom_range(0, 2));
                endcase
                filt_img.push_back(b);
            end
            if (flen >= 2 && $urandom_range(0, 2) == 0) begin
                filt_img[flen - 2] = CH_SLASH;
                filt_img[flen - 1] = CH_HASH;
            end
            send_request(CMD_CLEAR, 8'($urandom));
            foreach (filt_img[i]) send_request(CMD_APPEND, filt_img[i]);

            ntopics = (flen > 40) ? $urandom_range(1, 2) : $urandom_range(1, 5);
            repeat (ntopics) begin
                topic.delete();
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(0, 6)) topic.push_back(8'($urandom));
                end else begin
                    // derive a topic the filter should accept, then maybe damage it
                    stop = 1'b0;
                    for (int k = 0; k < filt_img.size() && !stop; k++) begin
                        if (filt_img[k] == CH_PLUS) begin
                            repeat ($urandom_range(0, 3))
                                topic.push_back(8'("a" + $urandom_range(0, 2)));
                        end else if (filt_img[k] == CH_HASH) begin
                            repeat ($urandom_range(0, 4))
                                topic.push_back(($urandom_range(0, 2) == 0) ? CH_SLASH : 8'("b"));
                            stop = 1'b1;
                        end else begin
                            topic.push_back(filt_img[k]);
                        end
                    end
                    case ($urandom_range(0, 5))
                        0: begin
                            if (topic.size() > 0) begin
                                idx = $urandom_range(0, topic.size() - 1);
                                topic[idx] = 8'($urandom);
                            end
                        end
                        1: topic.push_back(($urandom_range(0, 1) == 0) ? CH_SLASH : 8'("a"));
                        2: if (topic.size() > 0) void'(topic.pop_back());
                        default: ;
                    endcase
                end
                foreach (topic[k]) begin
                    if ($urandom_range(0, 24) == 0)
                        send_request(2'($urandom_range(0, 3)), 8'($urandom));
                    send_request(CMD_TOPIC, topic[k]);
                end
                send_request(CMD_END, 8'($urandom));
            end
        end

        @(negedge clk);
        in_valid = 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Sent %0d requests; checked %0d end-of-topic results", sent_count,
                 sb.result_count);
        $display("  %0d matched, %0d reported filter overflow", sb.match_count,
                 sb.overflow_count);
        if (sb.fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
